FILE: hw/rtl/md5_pkg.sv
`timescale 1ns / 1ps

package md5_pkg;

  // Initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Block buffer geometry and padding positions
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  // Byte source select for the block buffer write port
  typedef logic [1:0] byte_src_t;
  localparam byte_src_t SRC_INPUT = 2'd0;
  localparam byte_src_t SRC_PAD   = 2'd1;
  localparam byte_src_t SRC_ZERO  = 2'd2;
  localparam byte_src_t SRC_LEN   = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic      wr_en;
    byte_src_t byte_src;
    logic      count_en;
    logic      len_capture;
    logic      comp_start;
    logic      state_clear;
  } md5_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       comp_done;
  } md5_status_t;

  // Additive round constants
  function automatic logic [31:0] round_k(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Per-round left rotate amount
  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by each round
  function automatic logic [3:0] msg_word_idx(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
      default: g = 4'(r4 * 4'd7);
    endcase
    return g;
  endfunction

  // Round boolean function
  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] sh;
    sh = {x, x} << s;
    return sh[63:32];
  endfunction

endpackage

FILE: hw/rtl/md5_ifs.sv
`timescale 1ns / 1ps

// Message byte channel
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source(output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

// Digest channel
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_half;
  logic        half_index;
  logic        last_of_run;

  modport source(output valid, digest_half, half_index, last_of_run, input ready);
  modport sink(input valid, digest_half, half_index, last_of_run, output ready);
endinterface

FILE: hw/rtl/md5_dp.sv
`timescale 1ns / 1ps

module md5_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::md5_cmd_t   cmd,
  input  logic [7:0]          in_byte,
  output md5_pkg::md5_status_t status,
  output logic [63:0]         digest_lo,
  output logic [63:0]         digest_hi
);
  import md5_pkg::*;

  logic [31:0] chain_a_r, chain_b_r, chain_c_r, chain_d_r;
  logic [5:0]  fill_r;
  logic [63:0] msg_bytes_r;
  logic [63:0] msg_bytes_nxt;
  logic [63:0] bit_len_r;
  logic [31:0] blk_mem [16];
  logic [31:0] rd_word_r;
  logic [3:0]  rd_addr;
  logic [7:0]  wr_byte;
  logic        busy_r;
  logic [5:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] round_sum;
  logic [31:0] new_b;
  logic        last_round;

  // Select the byte to append
  always_comb begin
    case (cmd.byte_src)
      SRC_INPUT: wr_byte = in_byte;
      SRC_PAD:   wr_byte = PAD_BYTE;
      SRC_ZERO:  wr_byte = 8'h00;
      default:   wr_byte = bit_len_r[{fill_r[2:0], 3'b000} +: 8];
    endcase
  end

  // Block buffer: byte-lane writes, registered word read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      blk_mem[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_word_r <= blk_mem[rd_addr];
  end

  // Fetch the word for the coming round
  assign rd_addr = cmd.comp_start ? msg_word_idx(6'd0) : msg_word_idx(rnd_r + 6'd1);

  assign msg_bytes_nxt = msg_bytes_r + 64'(cmd.count_en);

  // Fill level and length counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.state_clear) begin
      fill_r      <= '0;
      msg_bytes_r <= '0;
    end else begin
      if (cmd.wr_en) begin
        fill_r <= fill_r + 6'd1;
      end
      msg_bytes_r <= msg_bytes_nxt;
    end
  end

  // Capture the bit length at end of message
  always_ff @(posedge clk) begin
    if (cmd.len_capture) begin
      bit_len_r <= {msg_bytes_nxt[60:0], 3'b000};
    end
  end

  // One compression round
  assign round_sum  = a_r + round_f(rnd_r[5:4], b_r, c_r, d_r) + rd_word_r + round_k(rnd_r);
  assign new_b      = b_r + rotl32(round_sum, rot_amt(rnd_r));
  assign last_round = busy_r && (rnd_r == LAST_ROUND);

  // Round sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else if (cmd.comp_start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
    end else if (busy_r) begin
      rnd_r <= rnd_r + 6'd1;
      if (last_round) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      a_r <= chain_a_r;
      b_r <= chain_b_r;
      c_r <= chain_c_r;
      d_r <= chain_d_r;
    end else if (busy_r) begin
      a_r <= d_r;
      b_r <= new_b;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  // Chaining values: fold in the block result, restore after the digest
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.state_clear) begin
      chain_a_r <= IV_A;
      chain_b_r <= IV_B;
      chain_c_r <= IV_C;
      chain_d_r <= IV_D;
    end else if (last_round) begin
      chain_a_r <= chain_a_r + d_r;
      chain_b_r <= chain_b_r + new_b;
      chain_c_r <= chain_c_r + b_r;
      chain_d_r <= chain_d_r + c_r;
    end
  end

  assign status.fill      = fill_r;
  assign status.comp_done = last_round;
  assign digest_lo        = {chain_b_r, chain_a_r};
  assign digest_hi        = {chain_d_r, chain_c_r};

endmodule

FILE: hw/rtl/md5_ctrl.sv
`timescale 1ns / 1ps

module md5_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_present,
  input  logic                 in_end,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic                 out_half,
  input  logic                 out_ready,
  input  md5_pkg::md5_status_t status,
  output md5_pkg::md5_cmd_t    cmd
);
  import md5_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PAD       = 3'd1;
  localparam logic [2:0] S_COMP_GO   = 3'd2;
  localparam logic [2:0] S_COMP_WAIT = 3'd3;
  localparam logic [2:0] S_OUT_LO    = 3'd4;
  localparam logic [2:0] S_OUT_HI    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       pad_active_r, pad_active_nxt;
  logic       pad_first_r, pad_first_nxt;
  logic       len_phase_r, len_phase_nxt;
  logic       in_acc;
  logic       blk_full;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign blk_full = (status.fill == FILL_LAST);

  // Next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    pad_active_nxt = pad_active_r;
    pad_first_nxt  = pad_first_r;
    len_phase_nxt  = len_phase_r;
    cmd            = '0;
    cmd.byte_src   = SRC_INPUT;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    out_half       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready        = 1'b1;
        cmd.wr_en       = in_acc && in_present;
        cmd.count_en    = in_acc && in_present;
        cmd.len_capture = in_acc && in_end;
        if (in_acc && in_end) begin
          pad_active_nxt = 1'b1;
          pad_first_nxt  = 1'b1;
        end
        if (in_acc && in_present && blk_full) begin
          state_nxt = S_COMP_GO;
        end else if (in_acc && in_end) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.wr_en = 1'b1;
        if (pad_first_r) begin
          cmd.byte_src  = SRC_PAD;
          pad_first_nxt = 1'b0;
        end else if (len_phase_r || status.fill == FILL_LEN) begin
          cmd.byte_src  = SRC_LEN;
          len_phase_nxt = 1'b1;
        end else begin
          cmd.byte_src = SRC_ZERO;
        end
        if (blk_full) begin
          state_nxt = S_COMP_GO;
        end
      end
      S_COMP_GO: begin
        cmd.comp_start = 1'b1;
        state_nxt      = S_COMP_WAIT;
      end
      S_COMP_WAIT: begin
        if (status.comp_done) begin
          if (!pad_active_r) begin
            state_nxt = S_IDLE;
          end else if (len_phase_r) begin
            state_nxt = S_OUT_LO;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      S_OUT_LO: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_OUT_HI;
        end
      end
      S_OUT_HI: begin
        out_valid = 1'b1;
        out_half  = 1'b1;
        if (out_ready) begin
          cmd.state_clear = 1'b1;
          pad_active_nxt  = 1'b0;
          pad_first_nxt   = 1'b0;
          len_phase_nxt   = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and padding flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pad_active_r <= 1'b0;
      pad_first_r  <= 1'b0;
      len_phase_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pad_active_r <= pad_active_nxt;
      pad_first_r  <= pad_first_nxt;
      len_phase_r  <= len_phase_nxt;
    end
  end

endmodule

FILE: hw/rtl/md5_hash_engine.sv
`timescale 1ns / 1ps
// Sequence: a byte transaction is taken whenever offered while idle; the byte that fills a
//   64-byte block adds a start state and 64 rounds, one round per cycle on a shared round unit.
// End of message: padding writes 1 byte per cycle, plus a start state and 64 rounds per
//   padded block, then the digest leaves as two transactions.
// Throughput: one transaction at a time; 1 byte per cycle while idle, none while busy.
// Reset: synchronous, active low; restores the initial chaining values, empties the buffer.

module md5_hash_engine (
  input logic             clk,
  input logic             rst_n,
  md5_in_if.sink          in_ch,
  md5_out_if.source       out_ch
);
  import md5_pkg::*;

  md5_cmd_t    cmd;
  md5_status_t status;
  logic [63:0] digest_lo;
  logic [63:0] digest_hi;
  logic        out_half;

  md5_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_present (in_ch.byte_present),
    .in_end     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_half   (out_half),
    .out_ready  (out_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  md5_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_byte   (in_ch.data_byte),
    .status    (status),
    .digest_lo (digest_lo),
    .digest_hi (digest_hi)
  );

  // Drive the digest half straight from the chaining registers
  assign out_ch.digest_half = out_half ? digest_hi : digest_lo;
  assign out_ch.half_index  = out_half;
  assign out_ch.last_of_run = out_half;

endmodule

FILE: hw/rtl/md5_hash_checker.sv
`timescale 1ns / 1ps

module md5_hash_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_half,
  input logic        out_half_index,
  input logic        out_last_of_run
);

  // A stalled digest transaction holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_half)
      && $stable(out_half_index))
    else $error("digest payload changed while stalled");

  // The second half is the last of the run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_half_index == out_last_of_run)
    else $error("last_of_run disagrees with half_index");

  // No byte is taken while a digest is offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while digest pending");

  // The first half is followed at once by the second
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_half_index |=> out_valid && out_half_index)
    else $error("second digest half missing");

  // After the final half the engine is idle again
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> !out_valid && in_ready)
    else $error("engine not idle after digest");

endmodule

bind md5_hash_engine md5_hash_checker u_md5_hash_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_half (out_ch.digest_half),
  .out_half_index  (out_ch.half_index),
  .out_last_of_run (out_ch.last_of_run)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import md5_pkg::*;

  // One message-byte transaction as queued for the driver
  typedef struct {
    bit [7:0] data;
    bit       present;
    bit       eom;
    bit       drain_first;  // hold off until every digest half has arrived
  } byte_item_t;

  // One expected digest-half transaction
  typedef struct {
    bit [63:0] half;
    bit        idx;
    bit        last;
  } digest_half_t;

  localparam bit HALF_LOW  = 1'b0;
  localparam bit HALF_HIGH = 1'b1;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES      = 300;
  localparam int RANDOM_ITEMS     = 700;

  // Additive constants and rotate amounts of the 64 MD5 rounds
  localparam bit [31:0] MIX_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int SHIFT_TBL [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  logic clk;
  logic rst_n;

  md5_in_if  in_bus ();
  md5_out_if out_bus ();

  md5_hash_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Predictor state
  bit [31:0]   chain [4];
  bit [7:0]    blk [64];
  int unsigned blk_fill;
  bit [63:0]   msg_len;

  byte_item_t   byte_items_q [$];
  digest_half_t digest_halves_due [$];

  int error_count;
  int offered_count;
  int taken_count;
  int halves_seen;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Restore the initial chaining values and an empty buffer
  function automatic void restart_digest();
    chain[0] = IV_A;
    chain[1] = IV_B;
    chain[2] = IV_C;
    chain[3] = IV_D;
    blk_fill = 0;
    msg_len  = '0;
  endfunction

  // Run the 64 rounds on the full block and fold into the chain
  function automatic void compress_block();
    bit [31:0] w [16];
    bit [31:0] a, b, c, d, f, t;
    int        g, s;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + w[g] + MIX_K[r];
      s = SHIFT_TBL[(r / 16) * 4 + r % 4];
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = b + t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  // Append one byte, compressing when the block fills
  function automatic void absorb_byte(bit [7:0] v);
    blk[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  // Absorb one accepted transaction; on end of message pad and queue the digest
  function automatic void digest_step(byte_item_t it);
    bit [63:0]    bit_len;
    digest_half_t h;
    if (it.present) begin
      absorb_byte(it.data);
      msg_len++;
    end
    if (it.eom) begin
      bit_len = msg_len << 3;
      absorb_byte(PAD_BYTE);
      while (blk_fill != FILL_LEN)
        absorb_byte(8'h00);
      for (int k = 0; k < 8; k++)
        absorb_byte(bit_len[8*k +: 8]);
      h.half = {chain[1], chain[0]};
      h.idx  = HALF_LOW;
      h.last = 1'b0;
      digest_halves_due.push_back(h);
      h.half = {chain[3], chain[2]};
      h.idx  = HALF_HIGH;
      h.last = 1'b1;
      digest_halves_due.push_back(h);
      restart_digest();
    end
  endfunction

  function automatic void queue_item(bit [7:0] data, bit present, bit eom, bit drain);
    byte_item_t it;
    it.data        = data;
    it.present     = present;
    it.eom         = eom;
    it.drain_first = drain;
    byte_items_q.push_back(it);
  endfunction

  // Check digest transactions, then predict from message-byte transactions
  always @(posedge clk) begin
    digest_half_t e;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        halves_seen++;
        if (digest_halves_due.size() == 0) begin
          $display("%0t: unexpected digest half %h idx %0d last %0d", $time,
                   out_bus.digest_half, out_bus.half_index, out_bus.last_of_run);
          error_count++;
        end else begin
          e = digest_halves_due.pop_front();
          if (out_bus.digest_half !== e.half) begin
            $display("%0t: digest_half expected %h actual %h", $time, e.half,
                     out_bus.digest_half);
            error_count++;
          end
          if (out_bus.half_index !== e.idx) begin
            $display("%0t: half_index expected %0d actual %0d", $time, e.idx,
                     out_bus.half_index);
            error_count++;
          end
          if (out_bus.last_of_run !== e.last) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time, e.last,
                     out_bus.last_of_run);
            error_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        digest_step('{in_bus.data_byte, in_bus.byte_present, in_bus.end_of_message, 1'b0});
        taken_count++;
      end
    end
  end

  // Sender: bursts of transactions separated by random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    byte_item_t it;
    if (rst_n && offered_count == taken_count) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (byte_items_q.size() != 0 && burst_left != 0 &&
          !(byte_items_q[0].drain_first && digest_halves_due.size() != 0)) begin
        it = byte_items_q.pop_front();
        in_bus.data_byte      <= it.data;
        in_bus.byte_present   <= it.present;
        in_bus.end_of_message <= it.eom;
        in_bus.valid          <= 1'b1;
        offered_count++;
        burst_left--;
      end else begin
        in_bus.valid <= 1'b0;
        if (burst_left == 0 && gap_left != 0)
          gap_left--;
      end
    end
  end

  // Receiver: own stall pattern, with a long hold-off now and then
  int hold_left;
  int next_hold_mark = 12;
  int rx_cycle;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        if (halves_seen >= next_hold_mark) begin
          hold_left      = LONG_HOLD_CYCLES;
          next_hold_mark = next_hold_mark + 36;
        end
        rx_cycle++;
        case ((rx_cycle / 200) % 4)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 1) == 0);
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ((rx_cycle % 5) != 0);
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int msg_items;
    int len;
    bit drain;
    bit end_on_byte;
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.data_byte      = '0;
    in_bus.byte_present   = 1'b0;
    in_bus.end_of_message = 1'b0;
    out_bus.ready         = 1'b0;
    restart_digest();

    // Directed: empty message, ignored item, byte on the end item, extreme bytes
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    queue_item(8'hff, 1'b0, 1'b0, 1'b0);
    queue_item("a", 1'b1, 1'b0, 1'b0);
    queue_item("b", 1'b1, 1'b0, 1'b0);
    queue_item("c", 1'b1, 1'b1, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0, 1'b1);
    queue_item(8'hff, 1'b1, 1'b0, 1'b0);
    queue_item(8'h5a, 1'b1, 1'b0, 1'b0);
    queue_item(8'ha5, 1'b0, 1'b0, 1'b0);
    queue_item(8'ha5, 1'b1, 1'b0, 1'b0);
    queue_item(8'h33, 1'b0, 1'b1, 1'b0);
    queue_item(8'hff, 1'b1, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1, 1'b0);

    // Random messages, lengths biased towards the padding boundaries
    msg_items = 0;
    while (msg_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0, 1: len = $urandom_range(0, 10);
        2: begin
          case ($urandom_range(0, 5))
            0:       len = 55;
            1:       len = 56;
            2:       len = 57;
            3:       len = 63;
            4:       len = 64;
            default: len = 65;
          endcase
        end
        default: len = $urandom_range(11, 130);
      endcase
      drain       = ($urandom_range(0, 7) == 0);
      end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, drain && i == 0);
        queue_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && i == len - 1,
                   drain && i == 0);
        msg_items++;
      end
      if (!end_on_byte) begin
        queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && len == 0);
        msg_items++;
      end
    end

    // Release reset
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction and every digest half, then let the engine settle
    while (byte_items_q.size() != 0 || offered_count != taken_count)
      @(posedge clk);
    while (digest_halves_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/md5_pkg.sv
hw/rtl/md5_ifs.sv
hw/rtl/md5_dp.sv
hw/rtl/md5_ctrl.sv
hw/rtl/md5_hash_engine.sv
hw/rtl/md5_hash_checker.sv
test/testbench.sv
